### design/msf_pkg.sv
// Shared types, widths, command codes and helpers for the masked frame statistics core.
package msf_pkg;

    // Field and accumulator widths.
    localparam int PIX_W    = 20;   // signed Q15.4 input sample
    localparam int MAG_W    = 19;   // magnitude of a positive sample
    localparam int CNT_W    = 17;   // pixel and valid counters
    localparam int SUM_W    = 35;   // sum of valid samples
    localparam int SQS_W    = 54;   // sum of squared valid samples
    localparam int SQR_W    = 2 * MAG_W;
    localparam int WIDE_W   = 72;   // shared width of the serial multiply and divide
    localparam int MULB_W   = 35;   // multiplier operand shifted out one bit per cycle
    localparam int VAR_W    = 40;   // variance and square root working width
    localparam int COV_W    = 15;
    localparam int ITER_W   = 7;

    localparam int MAX_PIXELS = 65536;
    localparam int COV_SCALE  = 25600;  // 100 percent in Q.8

    // Iteration counts of the serial units.
    localparam int MUL_ITERS  = MULB_W;
    localparam int DIV_ITERS  = WIDE_W;
    localparam int SQRT_ITERS = VAR_W / 2;

    // Datapath operations.
    typedef logic [2:0] t_op;
    localparam t_op OP_IDLE   = 3'd0;
    localparam t_op OP_ACCUM  = 3'd1;
    localparam t_op OP_LOAD   = 3'd2;
    localparam t_op OP_STEP   = 3'd3;
    localparam t_op OP_STORE  = 3'd4;
    localparam t_op OP_FINISH = 3'd5;

    // Jobs of the end-of-frame sequence, in the order they run.
    typedef logic [2:0] t_job;
    localparam t_job JOB_MUL_NSQ  = 3'd0;  // n * square_sum
    localparam t_job JOB_MUL_SS   = 3'd1;  // value_sum squared, subtracted
    localparam t_job JOB_DIV_VAR1 = 3'd2;  // divide by n
    localparam t_job JOB_DIV_VAR2 = 3'd3;  // divide by n again
    localparam t_job JOB_SQRT     = 3'd4;
    localparam t_job JOB_DIV_MEAN = 3'd5;
    localparam t_job JOB_MUL_COV  = 3'd6;  // n * 25600
    localparam t_job JOB_DIV_COV  = 3'd7;  // divide by pixel total
    localparam t_job JOB_LAST     = JOB_DIV_COV;

    typedef struct packed {
        t_op  op;
        t_job job;
    } t_dp_cmd;

    typedef struct packed {
        logic none_valid;   // no valid pixel in the current frame
        logic out_busy;     // output register holds a result that is not taken
    } t_dp_status;

    function automatic logic [ITER_W-1:0] job_iters(input t_job job);
        logic [ITER_W-1:0] n;
        unique case (job)
            JOB_MUL_NSQ, JOB_MUL_SS, JOB_MUL_COV: n = ITER_W'(MUL_ITERS);
            JOB_SQRT:                             n = ITER_W'(SQRT_ITERS);
            default:                              n = ITER_W'(DIV_ITERS);
        endcase
        return n;
    endfunction

endpackage

### design/msf_ctrl.sv
// Controller state machine: input handshake and end-of-frame job sequencing.
module msf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_frame_end,
    input  msf_pkg::t_dp_status i_status,
    output logic                o_in_stall,
    output msf_pkg::t_dp_cmd    o_cmd
);
    import msf_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_RUN   = 3'd3;
    localparam logic [2:0] S_STORE = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]        r_state, n_state;
    t_job              r_job,   n_job;
    logic [ITER_W-1:0] r_cnt,   n_cnt;
    logic              in_accept;

    // The input is held off during reset so that no transaction is taken then.
    assign o_in_stall = (r_state != S_IDLE) || !i_rst_n;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        n_state   = r_state;
        n_job     = r_job;
        n_cnt     = r_cnt;
        o_cmd.op  = OP_IDLE;
        o_cmd.job = r_job;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    o_cmd.op = OP_ACCUM;
                    if (i_frame_end) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                n_job = JOB_MUL_NSQ;
                if (i_status.none_valid) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.op = OP_LOAD;
                n_cnt    = job_iters(r_job) - ITER_W'(1);
                n_state  = S_RUN;
            end
            S_RUN: begin
                o_cmd.op = OP_STEP;
                if (r_cnt == '0) begin
                    n_state = S_STORE;
                end else begin
                    n_cnt = r_cnt - ITER_W'(1);
                end
            end
            S_STORE: begin
                o_cmd.op = OP_STORE;
                if (r_job == JOB_LAST) begin
                    n_state = S_OUT;
                end else begin
                    n_job   = r_job + t_job'(1);
                    n_state = S_LOAD;
                end
            end
            S_OUT: begin
                // Wait until the output register is free or being emptied.
                if (!i_status.out_busy) begin
                    o_cmd.op = OP_FINISH;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_job   <= JOB_MUL_NSQ;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_job   <= n_job;
            r_cnt   <= n_cnt;
        end
    end

endmodule

### design/msf_dp.sv
// Datapath: frame accumulators, serial multiplier, divider and square root, result register.
module msf_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  msf_pkg::t_dp_cmd                  i_cmd,
    input  logic signed [msf_pkg::PIX_W-1:0]  i_pixel_value,
    input  logic                              i_out_stall,
    output msf_pkg::t_dp_status               o_status,
    output logic                              o_out_valid,
    output logic [msf_pkg::CNT_W-1:0]         o_valid_count,
    output logic [msf_pkg::COV_W-1:0]         o_coverage_pct,
    output logic [msf_pkg::MAG_W-1:0]         o_min_valid,
    output logic [msf_pkg::MAG_W-1:0]         o_max_valid,
    output logic [msf_pkg::MAG_W-1:0]         o_mean_valid,
    output logic [msf_pkg::MAG_W-1:0]         o_std_valid
);
    import msf_pkg::*;

    // Frame accumulators.
    logic [CNT_W-1:0]  r_pix_total, r_valid_total;
    logic [MAG_W-1:0]  r_min, r_max;
    logic [SUM_W-1:0]  r_sum;
    logic [SQS_W-1:0]  r_sqsum;

    // Serial units and intermediate results.
    logic [WIDE_W-1:0] r_mul_a, r_mul_acc, r_wide, r_div_q;
    logic [MULB_W-1:0] r_mul_b;
    logic [CNT_W-1:0]  r_div_d, r_div_rem;
    logic [VAR_W-1:0]  r_var, r_sq_x, r_sq_res, r_sq_bit;
    logic [MAG_W-1:0]  r_mean, r_std;
    logic [COV_W-1:0]  r_cov;

    // Result register.
    logic              r_out_valid;
    logic [CNT_W-1:0]  r_out_count;
    logic [COV_W-1:0]  r_out_cov;
    logic [MAG_W-1:0]  r_out_min, r_out_max, r_out_mean, r_out_std;

    logic [MAG_W-1:0]  raw;
    logic              pix_ok, room;
    logic [SQR_W-1:0]  square;
    logic [CNT_W:0]    div_t, div_diff;
    logic              div_ge;
    logic [VAR_W-1:0]  sq_trial;
    logic              out_take;

    assign raw    = i_pixel_value[MAG_W-1:0];
    assign pix_ok = !i_pixel_value[PIX_W-1] && (raw != '0);
    assign room   = r_pix_total < CNT_W'(MAX_PIXELS);
    assign square = raw * raw;

    // One restoring divide step: shift in the next dividend bit.
    assign div_t    = {r_div_rem, r_div_q[WIDE_W-1]};
    assign div_diff = div_t - {1'b0, r_div_d};
    assign div_ge   = div_t >= {1'b0, r_div_d};

    assign sq_trial = r_sq_res + r_sq_bit;

    assign out_take = r_out_valid && !i_out_stall;

    assign o_status.none_valid = (r_valid_total == '0);
    assign o_status.out_busy   = r_out_valid && i_out_stall;

    assign o_out_valid    = r_out_valid;
    assign o_valid_count  = r_out_count;
    assign o_coverage_pct = r_out_cov;
    assign o_min_valid    = r_out_min;
    assign o_max_valid    = r_out_max;
    assign o_mean_valid   = r_out_mean;
    assign o_std_valid    = r_out_std;

    // Accumulators and the output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_total   <= '0;
            r_valid_total <= '0;
            r_min         <= '1;
            r_max         <= '0;
            r_sum         <= '0;
            r_sqsum       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (out_take && i_cmd.op != OP_FINISH) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.op == OP_ACCUM && room) begin
                r_pix_total <= r_pix_total + CNT_W'(1);
                if (pix_ok) begin
                    r_valid_total <= r_valid_total + CNT_W'(1);
                    if (raw < r_min) begin
                        r_min <= raw;
                    end
                    if (raw > r_max) begin
                        r_max <= raw;
                    end
                    r_sum   <= r_sum + SUM_W'(raw);
                    r_sqsum <= r_sqsum + SQS_W'(square);
                end
            end
            if (i_cmd.op == OP_FINISH) begin
                r_pix_total   <= '0;
                r_valid_total <= '0;
                r_min         <= '1;
                r_max         <= '0;
                r_sum         <= '0;
                r_sqsum       <= '0;
                r_out_valid   <= 1'b1;
            end
        end
    end

    // End-of-frame arithmetic and the result payload.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_mul_acc <= '0;
                r_div_rem <= '0;
                r_sq_x    <= r_var;
                r_sq_res  <= '0;
                r_sq_bit  <= VAR_W'(1) << (VAR_W - 2);
                unique case (i_cmd.job)
                    JOB_MUL_NSQ: begin
                        r_mul_a <= WIDE_W'(r_sqsum);
                        r_mul_b <= MULB_W'(r_valid_total);
                    end
                    JOB_MUL_SS: begin
                        r_mul_a <= WIDE_W'(r_sum);
                        r_mul_b <= r_sum;
                    end
                    JOB_MUL_COV: begin
                        r_mul_a <= WIDE_W'(r_valid_total);
                        r_mul_b <= MULB_W'(COV_SCALE);
                    end
                    JOB_DIV_MEAN: begin
                        r_div_q <= WIDE_W'(r_sum);
                        r_div_d <= r_valid_total;
                    end
                    JOB_DIV_COV: begin
                        r_div_q <= r_wide;
                        r_div_d <= r_pix_total;
                    end
                    default: begin
                        r_div_q <= r_wide;
                        r_div_d <= r_valid_total;
                    end
                endcase
            end
            OP_STEP: begin
                // Shift-add multiply, restoring divide and digit-by-digit root
                // advance together; only the job's own result is stored.
                if (r_mul_b[0]) begin
                    r_mul_acc <= r_mul_acc + r_mul_a;
                end
                r_mul_a <= r_mul_a << 1;
                r_mul_b <= r_mul_b >> 1;

                r_div_q   <= {r_div_q[WIDE_W-2:0], div_ge};
                r_div_rem <= div_ge ? div_diff[CNT_W-1:0] : div_t[CNT_W-1:0];

                if (r_sq_x >= sq_trial) begin
                    r_sq_x   <= r_sq_x - sq_trial;
                    r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                end else begin
                    r_sq_res <= r_sq_res >> 1;
                end
                r_sq_bit <= r_sq_bit >> 2;
            end
            OP_STORE: begin
                unique case (i_cmd.job)
                    JOB_MUL_NSQ:  r_wide <= r_mul_acc;
                    JOB_MUL_SS:   r_wide <= (r_wide >= r_mul_acc) ? r_wide - r_mul_acc : '0;
                    JOB_DIV_VAR1: r_wide <= r_div_q;
                    JOB_DIV_VAR2: r_var  <= r_div_q[VAR_W-1:0];
                    JOB_SQRT:     r_std  <= r_sq_res[MAG_W-1:0];
                    JOB_DIV_MEAN: r_mean <= r_div_q[MAG_W-1:0];
                    JOB_MUL_COV:  r_wide <= r_mul_acc;
                    default:      r_cov  <= r_div_q[COV_W-1:0];
                endcase
            end
            OP_FINISH: begin
                if (o_status.none_valid) begin
                    r_out_count <= '0;
                    r_out_cov   <= '0;
                    r_out_min   <= '0;
                    r_out_max   <= '0;
                    r_out_mean  <= '0;
                    r_out_std   <= '0;
                end else begin
                    r_out_count <= r_valid_total;
                    r_out_cov   <= r_cov;
                    r_out_min   <= r_min;
                    r_out_max   <= r_max;
                    r_out_mean  <= r_mean;
                    r_out_std   <= r_std;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

### design/masked_frame_statistics_core.sv
// Top level of the masked frame statistics core: controller plus datapath.
//
//  channel  direction  handshake                  payload
//  pixel    in         i_in_valid / o_in_stall    i_pixel_value, i_frame_end
//  result   out        o_out_valid / i_out_stall  o_valid_count, o_coverage_pct,
//                                                 o_min_valid, o_max_valid,
//                                                 o_mean_valid, o_std_valid
//
// Pixels are taken one per cycle while the core accumulates a frame.
// The transaction that carries frame_end starts a sequence of eight jobs on the
// shared serial units (three multiplies, four divides and one square root),
// during which o_in_stall is high; a frame without valid pixels skips the jobs
// and stalls the input only through the start and output states.
// A finished result sits in the output register and the next frame streams in
// meanwhile; only the next result waits for it to be taken.
// Reset is synchronous, active low, clears all accumulators and holds o_in_stall high.
module masked_frame_statistics_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [msf_pkg::PIX_W-1:0]  i_pixel_value,
    input  logic                              i_frame_end,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [msf_pkg::CNT_W-1:0]         o_valid_count,
    output logic [msf_pkg::COV_W-1:0]         o_coverage_pct,
    output logic [msf_pkg::MAG_W-1:0]         o_min_valid,
    output logic [msf_pkg::MAG_W-1:0]         o_max_valid,
    output logic [msf_pkg::MAG_W-1:0]         o_mean_valid,
    output logic [msf_pkg::MAG_W-1:0]         o_std_valid
);
    import msf_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    msf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_frame_end (i_frame_end),
        .i_status    (status),
        .o_in_stall  (o_in_stall),
        .o_cmd       (cmd)
    );

    msf_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_pixel_value  (i_pixel_value),
        .i_out_stall    (i_out_stall),
        .o_status       (status),
        .o_out_valid    (o_out_valid),
        .o_valid_count  (o_valid_count),
        .o_coverage_pct (o_coverage_pct),
        .o_min_valid    (o_min_valid),
        .o_max_valid    (o_max_valid),
        .o_mean_valid   (o_mean_valid),
        .o_std_valid    (o_std_valid)
    );

endmodule
